// ===== rtl/hsv_pkg.sv =====
package hsv_pkg;

  localparam int HueW    = 9;
  localparam int ChanW   = 8;
  localparam int SectorW = 4;
  localparam int FracW   = 6;
  localparam int NumW    = 14;
  localparam int ProdW   = 22;
  localparam int CfgIdxW = 2;
  localparam int Lanes   = 3;

  // hue / 60 by reciprocal: exact for every 9-bit hue
  localparam int              SectorRecipW = 11;
  localparam logic [10:0]     SectorRecip  = 11'd1093;
  localparam int              SectorShift  = 16;

  // level / 15300 by reciprocal: estimate is the quotient or one below it
  localparam int              LevelRecipW  = 17;
  localparam logic [16:0]     LevelRecip   = 17'd70179;
  localparam int              LevelShift   = 30;

  localparam logic [HueW-1:0]  FullTurn    = 9'd360;
  localparam logic [FracW-1:0] SectorDeg   = 6'd60;
  localparam logic [NumW-1:0]  UnitXSector = 14'd15300;

  localparam logic [CfgIdxW-1:0] CfgSaturation = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBrightness = 2'd1;

  localparam logic [ChanW-1:0] SatReset = 8'd255;
  localparam logic [ChanW-1:0] ValReset = 8'd153;

  localparam logic [SectorW-1:0] Sector0 = 4'd0;
  localparam logic [SectorW-1:0] Sector1 = 4'd1;
  localparam logic [SectorW-1:0] Sector2 = 4'd2;
  localparam logic [SectorW-1:0] Sector3 = 4'd3;
  localparam logic [SectorW-1:0] Sector4 = 4'd4;

  // lane order of the three levels
  localparam int LaneQ = 0;
  localparam int LaneT = 1;
  localparam int LaneP = 2;

  typedef logic [ChanW-1:0]   chan_t;
  typedef logic [SectorW-1:0] sector_t;
  typedef logic [FracW-1:0]   frac_t;
  typedef logic [NumW-1:0]    num_t;
  typedef logic [ProdW-1:0]   prod_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  function automatic rgb_t route(sector_t sector, chan_t v, chan_t p, chan_t q, chan_t t);
    rgb_t res;
    case (sector)
      Sector0: res = '{red: v, green: t, blue: p};
      Sector1: res = '{red: q, green: v, blue: p};
      Sector2: res = '{red: p, green: v, blue: t};
      Sector3: res = '{red: p, green: q, blue: v};
      Sector4: res = '{red: t, green: p, blue: v};
      default: res = '{red: v, green: p, blue: q};
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/hsv_hue_if.sv =====
interface hsv_hue_if;
  import hsv_pkg::*;

  logic            valid;
  logic            ready;
  logic [HueW-1:0] hue_degrees;

  modport source (output valid, output hue_degrees, input ready);
  modport sink   (input valid, input hue_degrees, output ready);
endinterface

// ===== rtl/hsv_rgb_if.sv =====
interface hsv_rgb_if;
  import hsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/hsv_cfg_if.sv =====
interface hsv_cfg_if;
  import hsv_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ChanW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter.
// in_hue  : one hue item (0..360 degrees, 360 is 0) per valid/ready handshake.
// out_rgb : one red/green/blue item for every hue item, in order.
// cfg_wr  : register writes, index 0 saturation, index 1 brightness (n/255);
//           other indices are ignored. Always ready. Write only while idle.
// Rate    : one item per cycle while out_rgb is not stalled; a six-stage
//           pipeline (sector, remainder, saturation product, brightness
//           product, reciprocal estimate, correction and sector mux), one
//           multiply per lane in the product, estimate and correction stages.
// Stalls  : each stage holds while the stage after it is full and held, so
//           bubbles are squeezed out and in_hue.ready only drops once every
//           stage is occupied behind a stalled out_rgb.
// Reset   : rst_n synchronous, active low; empties the pipeline and loads
//           saturation 255 and brightness 153.
module hsv_to_rgb_converter (
  input  logic             clk,
  input  logic             rst_n,
  hsv_hue_if.sink          in_hue,
  hsv_rgb_if.source        out_rgb,
  hsv_cfg_if.sink          cfg_wr
);
  import hsv_pkg::*;

  localparam int Stages = 6;

  logic [Stages-1:0] v_r;
  logic [Stages-1:0] en;

  chan_t sat_r;
  chan_t val_r;

  // stage 1
  logic [HueW-1:0] s1_hue_r;
  sector_t         s1_sector_r;
  chan_t           s1_sat_r;
  chan_t           s1_val_r;
  // stage 2
  sector_t         s2_sector_r;
  frac_t           s2_frac_r [Lanes];
  chan_t           s2_sat_r;
  chan_t           s2_val_r;
  // stage 3
  sector_t         s3_sector_r;
  num_t            s3_num_r [Lanes];
  chan_t           s3_val_r;
  // stage 4
  sector_t         s4_sector_r;
  prod_t           s4_x_r [Lanes];
  chan_t           s4_val_r;
  // stage 5
  sector_t         s5_sector_r;
  prod_t           s5_x_r [Lanes];
  chan_t           s5_est_r [Lanes];
  chan_t           s5_val_r;
  // output
  rgb_t            out_r;

  logic [HueW+SectorRecipW-1:0]  sec_prod;
  sector_t                       sector_nxt;
  logic [HueW-1:0]               rem_full;
  frac_t                         rem_nxt;
  logic [ProdW+LevelRecipW-1:0]  est_prod [Lanes];
  prod_t                         chk      [Lanes];
  chan_t                         lev_nxt  [Lanes];

  // stage enables
  always_comb begin
    en[Stages-1] = !v_r[Stages-1] || out_rgb.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_hue.ready = en[0];
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      sat_r <= SatReset;
      val_r <= ValReset;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_hue.valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          CfgSaturation: sat_r <= cfg_wr.data;
          CfgBrightness: val_r <= cfg_wr.data;
          default: ;
        endcase
      end
    end
  end

  // stage 1: sector
  always_comb begin
    sec_prod   = in_hue.hue_degrees * SectorRecip;
    sector_nxt = (in_hue.hue_degrees == FullTurn) ? Sector0
                 : sec_prod[SectorShift +: SectorW];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_hue_r    <= (in_hue.hue_degrees == FullTurn) ? '0 : in_hue.hue_degrees;
      s1_sector_r <= sector_nxt;
      s1_sat_r    <= sat_r;
      s1_val_r    <= val_r;
    end
  end

  // stage 2: remainder and the three fractions
  always_comb begin
    rem_full = s1_hue_r - HueW'(s1_sector_r) * HueW'(SectorDeg);
    rem_nxt  = rem_full[FracW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_sector_r        <= s1_sector_r;
      s2_frac_r[LaneQ]   <= rem_nxt;
      s2_frac_r[LaneT]   <= SectorDeg - rem_nxt;
      s2_frac_r[LaneP]   <= SectorDeg;
      s2_sat_r           <= s1_sat_r;
      s2_val_r           <= s1_val_r;
    end
  end

  // stage 3: 15300 - sat*frac
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_sector_r <= s2_sector_r;
      s3_val_r    <= s2_val_r;
      for (int i = 0; i < Lanes; i++) begin
        s3_num_r[i] <= UnitXSector - NumW'(s2_sat_r) * NumW'(s2_frac_r[i]);
      end
    end
  end

  // stage 4: val * num
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_sector_r <= s3_sector_r;
      s4_val_r    <= s3_val_r;
      for (int i = 0; i < Lanes; i++) begin
        s4_x_r[i] <= s3_val_r * s3_num_r[i];
      end
    end
  end

  // stage 5: quotient estimate
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      est_prod[i] = s4_x_r[i] * LevelRecip;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_sector_r <= s4_sector_r;
      s5_val_r    <= s4_val_r;
      for (int i = 0; i < Lanes; i++) begin
        s5_x_r[i]   <= s4_x_r[i];
        s5_est_r[i] <= est_prod[i][LevelShift +: ChanW];
      end
    end
  end

  // stage 6: correct estimate, sector mux
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      chk[i]     = s5_x_r[i] - ProdW'(s5_est_r[i]) * ProdW'(UnitXSector);
      lev_nxt[i] = (chk[i] >= ProdW'(UnitXSector)) ? s5_est_r[i] + 1'b1 : s5_est_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_r <= route(s5_sector_r, s5_val_r, lev_nxt[LaneP], lev_nxt[LaneQ], lev_nxt[LaneT]);
    end
  end

  assign out_rgb.valid = v_r[Stages-1];
  assign out_rgb.red   = out_r.red;
  assign out_rgb.green = out_r.green;
  assign out_rgb.blue  = out_r.blue;

endmodule

// ===== rtl/hsv_checker.sv =====
module hsv_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [hsv_pkg::ChanW-1:0] out_red,
  input logic [hsv_pkg::ChanW-1:0] out_green,
  input logic [hsv_pkg::ChanW-1:0] out_blue
);
  import hsv_pkg::*;

  // a stalled result item holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("result item changed while stalled");

  // a draining output lets the whole pipe move
  a_ready_follows: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // an empty output stage never blocks the input
  a_empty_ready: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_hue.ready),
  .out_valid (out_rgb.valid),
  .out_ready (out_rgb.ready),
  .out_red   (out_rgb.red),
  .out_green (out_rgb.green),
  .out_blue  (out_rgb.blue)
);
